// ===== design/tape_block_stream_deframer_macros.svh =====
// ============================================================================
// Assertion macros for the tape block stream deframer
// Clocked property checks, with and without a reset disable.
// ============================================================================
`ifndef TAPE_BLOCK_STREAM_DEFRAMER_MACROS_SVH
`define TAPE_BLOCK_STREAM_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define TBSD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked on every edge, reset included
`define TBSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TBSD_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define TBSD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/tbsd_pkg.sv =====
// ============================================================================
// tbsd_pkg
// Result record, result kinds, error codes and framing bytes of the deframer.
// ============================================================================
`default_nettype none

package tbsd_pkg;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_BAD     = 2'd1;
	localparam logic [1:0] KIND_TRAILER = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_STATUS   = 3'd1;
	localparam logic [2:0] ERR_BLOCK    = 3'd2;
	localparam logic [2:0] ERR_LENGTH   = 3'd3;
	localparam logic [2:0] ERR_NIBBLE   = 3'd4;
	localparam logic [2:0] ERR_CHECKSUM = 3'd5;
	localparam logic [2:0] ERR_ZERO_LEN = 3'd6;

	localparam logic [7:0] STAT_BAD  = 8'hFD;
	localparam logic [7:0] STAT_SUM  = 8'hFE;
	localparam logic [7:0] STAT_GOOD = 8'hFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] value;
		logic [15:0] block_number;
		logic [2:0]  error_code;
		logic [15:0] bad_total;
		logic        last;
	} res_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [11:0] value,
		input logic [15:0] blk, input logic [2:0] err, input logic [15:0] bad,
		input logic last);
		res_t r;
		r.kind         = kind;
		r.value        = value;
		r.block_number = blk;
		r.error_code   = err;
		r.bad_total    = bad;
		r.last         = last;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/tape_block_stream_deframer.sv =====
// ============================================================================
// tape_block_stream_deframer
// Deframes a byte stream of tape blocks into data words, notices and trailer.
// ============================================================================
// One received byte is taken per clock while the buffer has room. Each byte
// updates the framing state and writes zero to three results into a
// four-entry output buffer, which registers them for the output.
// A byte is taken whenever the buffer holds at most one result, so with the
// output side always ready the block runs at one byte per cycle. Only the
// checksum trailer (three results) and an odd-nibble error (two results) write
// more than one result, and both end the stream. After the end of the stream
// or any error, bytes are still taken but ignored until reset.
// ============================================================================
`default_nettype none
`include "tape_block_stream_deframer_macros.svh"

module tape_block_stream_deframer
	import tbsd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [11:0]      value,
	output logic [15:0]      block_number,
	output logic [2:0]       error_code,
	output logic [15:0]      bad_block_total,
	output logic             last
);

	typedef enum logic [3:0] {
		PH_STATUS, PH_BLK_LO, PH_BLK_HI, PH_LEN_LO, PH_LEN_HI,
		PH_DAT_1, PH_DAT_2, PH_DAT_3, PH_SUM_LO, PH_SUM_HI, PH_HALT
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  acc_q, acc_n;
	logic [15:0] exp_q, exp_n;
	logic [15:0] len_q, len_n;
	logic [15:0] left_q, left_n;
	logic [11:0] sum_q, sum_n;
	logic [15:0] bad_q, bad_n;

	res_t        fifo_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  cnt_q;
	logic [1:0]  push_n;
	res_t        push_r [3];

	logic        accept, pop;
	logic [15:0] w16, len_pick;
	logic [11:0] word;

	assign accept    = in_valid && in_ready;
	assign out_valid = cnt_q != 3'd0;
	assign pop       = out_valid && out_ready;
	assign in_ready  = cnt_q <= 3'd1;

	assign w16 = {rx_byte, acc_q};

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		exp_n     = exp_q;
		len_n     = len_q;
		left_n    = left_q;
		sum_n     = sum_q;
		bad_n     = bad_q;
		push_n    = 2'd0;
		push_r[0] = '0;
		push_r[1] = '0;
		push_r[2] = '0;
		len_pick  = (len_q == 16'd0) ? w16 : len_q;
		word      = '0;
		case (phase_q)
			PH_STATUS: begin
				if (rx_byte == STAT_BAD) begin
					if (bad_q != 16'hFFFF) begin
						bad_n = bad_q + 16'd1;
					end
					push_r[0] = mk_res(KIND_BAD, 12'd0, exp_q, ERR_NONE, bad_n, 1'b0);
					push_n    = 2'd1;
					phase_n   = PH_BLK_LO;
				end else if (rx_byte == STAT_SUM) begin
					phase_n = PH_SUM_LO;
				end else if (rx_byte == STAT_GOOD) begin
					phase_n = PH_BLK_LO;
				end else begin
					push_r[0] = mk_res(KIND_ERROR, 12'd0, exp_q, ERR_STATUS, bad_q, 1'b1);
					push_n    = 2'd1;
					phase_n   = PH_HALT;
				end
			end
			PH_BLK_LO, PH_LEN_LO, PH_SUM_LO, PH_DAT_1: begin
				acc_n = rx_byte;
				case (phase_q)
					PH_BLK_LO: phase_n = PH_BLK_HI;
					PH_LEN_LO: phase_n = PH_LEN_HI;
					PH_SUM_LO: phase_n = PH_SUM_HI;
					default:   phase_n = PH_DAT_2;
				endcase
			end
			PH_BLK_HI: begin
				if (w16 != exp_q) begin
					push_r[0] = mk_res(KIND_ERROR, 12'd0, exp_q, ERR_BLOCK, bad_q, 1'b1);
					push_n    = 2'd1;
					phase_n   = PH_HALT;
				end else begin
					phase_n = PH_LEN_LO;
				end
			end
			PH_LEN_HI: begin
				if (w16 == 16'd0) begin
					push_r[0] = mk_res(KIND_ERROR, 12'd0, exp_q, ERR_ZERO_LEN, bad_q, 1'b1);
					push_n    = 2'd1;
					phase_n   = PH_HALT;
				end else if (w16 != len_pick) begin
					push_r[0] = mk_res(KIND_ERROR, 12'd0, exp_q, ERR_LENGTH, bad_q, 1'b1);
					push_n    = 2'd1;
					phase_n   = PH_HALT;
				end else begin
					len_n   = len_pick;
					left_n  = len_pick;
					phase_n = PH_DAT_1;
				end
			end
			PH_DAT_2: begin
				word      = {rx_byte[3:0], acc_q};
				sum_n     = sum_q + word;
				left_n    = left_q - 16'd1;
				acc_n     = {4'd0, rx_byte[7:4]};
				push_r[0] = mk_res(KIND_DATA, word, exp_q, ERR_NONE, bad_q, 1'b0);
				push_n    = 2'd1;
				if (left_n == 16'd0) begin
					// odd final word: spare nibble must be zero
					if (rx_byte[7:4] != 4'd0) begin
						push_r[1] = mk_res(KIND_ERROR, 12'd0, exp_q, ERR_NIBBLE, bad_q, 1'b1);
						push_n    = 2'd2;
						phase_n   = PH_HALT;
					end else begin
						exp_n   = exp_q + 16'd1;
						phase_n = PH_STATUS;
					end
				end else begin
					phase_n = PH_DAT_3;
				end
			end
			PH_DAT_3: begin
				word      = {rx_byte, acc_q[3:0]};
				sum_n     = sum_q + word;
				left_n    = left_q - 16'd1;
				acc_n     = 8'd0;
				push_r[0] = mk_res(KIND_DATA, word, exp_q, ERR_NONE, bad_q, 1'b0);
				push_n    = 2'd1;
				if (left_n == 16'd0) begin
					exp_n   = exp_q + 16'd1;
					phase_n = PH_STATUS;
				end else begin
					phase_n = PH_DAT_1;
				end
			end
			PH_SUM_HI: begin
				phase_n = PH_HALT;
				if ((w16[11:0] + sum_q) != 12'd0) begin
					push_r[0] = mk_res(KIND_ERROR, 12'd0, exp_q, ERR_CHECKSUM, bad_q, 1'b1);
					push_n    = 2'd1;
				end else begin
					push_r[0] = mk_res(KIND_TRAILER, len_q[11:0], exp_q, ERR_NONE, bad_q, 1'b0);
					push_r[1] = mk_res(KIND_TRAILER, 12'd0, exp_q, ERR_NONE, bad_q, 1'b0);
					push_r[2] = mk_res(KIND_TRAILER, 12'd0, exp_q, ERR_NONE, bad_q, 1'b1);
					push_n    = 2'd3;
				end
			end
			default: begin
				phase_n = PH_HALT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_STATUS;
			acc_q    <= '0;
			exp_q    <= '0;
			len_q    <= '0;
			left_q   <= '0;
			sum_q    <= '0;
			bad_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				phase_q  <= phase_n;
				acc_q    <= acc_n;
				exp_q    <= exp_n;
				len_q    <= len_n;
				left_q   <= left_n;
				sum_q    <= sum_n;
				bad_q    <= bad_n;
				wr_ptr_q <= wr_ptr_q + push_n;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + (accept ? {1'b0, push_n} : 3'd0) - {2'b0, pop};
		end
	end

	// result buffer payload, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (accept && (2'(i) < push_n)) begin
				fifo_q[wr_ptr_q + 2'(i)] <= push_r[i];
			end
		end
	end

	assign kind            = fifo_q[rd_ptr_q].kind;
	assign value           = fifo_q[rd_ptr_q].value;
	assign block_number    = fifo_q[rd_ptr_q].block_number;
	assign error_code      = fifo_q[rd_ptr_q].error_code;
	assign bad_block_total = fifo_q[rd_ptr_q].bad_total;
	assign last            = fifo_q[rd_ptr_q].last;

	`TBSD_ASSERT_ALWAYS(a_cnt_bound, clk, !arst_n || (cnt_q <= 3'd4), "result buffer overfilled")
	`TBSD_ASSERT_RST(a_run_cnt, clk, arst_n, (phase_q != PH_HALT) |-> (cnt_q <= 3'd2), "too many results queued while running")
	`TBSD_ASSERT_RST(a_last_halt, clk, arst_n, (out_valid && last) |-> (phase_q == PH_HALT), "final result queued without halting")
	`TBSD_ASSERT_RST(a_bad_mono, clk, arst_n, 1'b1 |=> (bad_q >= $past(bad_q)), "bad block count went down")

endmodule

`default_nettype wire

// ===== test/tb_tape_block_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_tape_block_stream_deframer
// Self-checking bench for the tape block stream deframer. A generator builds
// one framed byte stream: corner-value blocks first, then good and bad blocks
// with random data, and one closing event picked at random (a good checksum or
// one of the framing errors), followed by bytes the halted block must ignore.
// Every accepted byte runs through a local deframer model; each result taken
// from the block is compared field by field with the oldest expected one.
// Both sides throttle at random.
// ----------------------------------------------------------------------------
module tb_tape_block_stream_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import tbsd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int STREAM_BYTES = 440;
	localparam logic [11:0] CORNER_WORDS [8] = '{12'hFFF, 12'h000, 12'h800, 12'h7FF,
		12'h001, 12'hAAA, 12'h555, 12'hF0F};

	typedef enum logic [3:0] {
		ST_STATUS, ST_BLK_LO, ST_BLK_HI, ST_LEN_LO, ST_LEN_HI,
		ST_DAT_1, ST_DAT_2, ST_DAT_3, ST_SUM_LO, ST_SUM_HI, ST_DONE
	} deframe_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [11:0] value;
	logic [15:0] block_number;
	logic [2:0]  error_code;
	logic [15:0] bad_block_total;
	logic        last;

	// bytes waiting to be sent; a set hold bit makes the sender drain first
	logic [7:0] tx_bytes[$];
	bit         tx_hold[$];
	res_t       pending_res[$];

	// local deframer model state
	deframe_state_t st = ST_STATUS;
	logic [15:0] acc = '0;
	logic [15:0] want_blk = '0;
	logic [15:0] latched_len = '0;
	logic [15:0] words_todo = '0;
	logic [11:0] word_sum = '0;
	logic [15:0] bad_cnt = '0;

	// stream generator state
	logic [15:0] g_blk = '0;
	logic [15:0] g_len = '0;
	logic [11:0] g_sum = '0;
	int          n_gen = 0;
	int          n_blocks = 0;
	string       ending = "";

	int n_taken = 0;
	int n_checked = 0;
	int n_fail = 0;
	int n_cycles = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int stall_pick;

	tape_block_stream_deframer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.value           (value),
		.block_number    (block_number),
		.error_code      (error_code),
		.bad_block_total (bad_block_total),
		.last            (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d of %0d bytes taken, %0d results pending",
				$time, n_taken, n_gen, pending_res.size());
			$display("tape_block_stream_deframer verification failed");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, and idle-free stretches
	function automatic int idle_len(input int seq);
		int r;
		if (seq % 128 < 32)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void push_res(input logic [1:0] k, input logic [11:0] v,
		input logic [2:0] err, input logic lst);
		pending_res.push_back(mk_res(k, v, want_blk, err, bad_cnt, lst));
	endfunction

	function automatic void halt_on(input logic [2:0] err);
		push_res(KIND_ERROR, 12'h000, err, 1'b1);
		st = ST_DONE;
	endfunction

	function automatic void take_word(input logic [11:0] w);
		word_sum = word_sum + w;
		push_res(KIND_DATA, w, ERR_NONE, 1'b0);
		words_todo = words_todo - 16'd1;
	endfunction

	// advances the model by one byte and queues the results it causes
	function automatic void deframe_byte(input logic [7:0] b);
		logic [15:0] w;
		w = {b, acc[7:0]};
		case (st)
		ST_STATUS: begin
			if (b == STAT_BAD) begin
				if (bad_cnt != 16'hFFFF)
					bad_cnt = bad_cnt + 16'd1;
				push_res(KIND_BAD, 12'h000, ERR_NONE, 1'b0);
				st = ST_BLK_LO;
			end else if (b == STAT_SUM) begin
				st = ST_SUM_LO;
			end else if (b == STAT_GOOD) begin
				st = ST_BLK_LO;
			end else begin
				halt_on(ERR_STATUS);
			end
		end
		ST_BLK_LO: begin
			acc = {8'h00, b};
			st = ST_BLK_HI;
		end
		ST_BLK_HI: begin
			acc = w;
			if (w != want_blk)
				halt_on(ERR_BLOCK);
			else
				st = ST_LEN_LO;
		end
		ST_LEN_LO: begin
			acc = {8'h00, b};
			st = ST_LEN_HI;
		end
		ST_LEN_HI: begin
			acc = w;
			if (w == 16'h0000) begin
				halt_on(ERR_ZERO_LEN);
			end else begin
				if (latched_len == 16'h0000)
					latched_len = w;
				if (w != latched_len) begin
					halt_on(ERR_LENGTH);
				end else begin
					words_todo = latched_len;
					st = ST_DAT_1;
				end
			end
		end
		ST_DAT_1: begin
			acc = {8'h00, b};
			st = ST_DAT_2;
		end
		ST_DAT_2: begin
			take_word({b[3:0], acc[7:0]});
			acc = {12'h000, b[7:4]};
			if (words_todo == 16'h0000) begin
				// odd word count: the upper nibble of this byte must be spare
				if (acc != 16'h0000) begin
					halt_on(ERR_NIBBLE);
				end else begin
					want_blk = want_blk + 16'd1;
					st = ST_STATUS;
				end
			end else begin
				st = ST_DAT_3;
			end
		end
		ST_DAT_3: begin
			take_word({b, acc[3:0]});
			acc = '0;
			if (words_todo == 16'h0000) begin
				want_blk = want_blk + 16'd1;
				st = ST_STATUS;
			end else begin
				st = ST_DAT_1;
			end
		end
		ST_SUM_LO: begin
			acc = {8'h00, b};
			st = ST_SUM_HI;
		end
		ST_SUM_HI: begin
			acc = w;
			if (w[11:0] + word_sum != 12'h000) begin
				halt_on(ERR_CHECKSUM);
			end else begin
				push_res(KIND_TRAILER, latched_len[11:0], ERR_NONE, 1'b0);
				push_res(KIND_TRAILER, 12'h000, ERR_NONE, 1'b0);
				push_res(KIND_TRAILER, 12'h000, ERR_NONE, 1'b1);
				st = ST_DONE;
			end
		end
		default: ;
		endcase
	endfunction

	task automatic cmp(input string fld, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
			n_fail++;
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
				n_taken++;
			end
			if (in_valid && !in_ready) begin
				// hold the item until it is taken
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (tx_bytes.size() != 0 && !(tx_hold[0] && pending_res.size() != 0)) begin
				in_valid <= 1'b1;
				rx_byte <= tx_bytes.pop_front();
				void'(tx_hold.pop_front());
				send_gap <= idle_len(n_taken);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_res.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d value %0h err %0d",
						$time, kind, value, error_code);
					n_fail++;
				end else begin
					cmp("kind", pending_res[0].kind, kind);
					cmp("value", pending_res[0].value, value);
					cmp("block_number", pending_res[0].block_number, block_number);
					cmp("error_code", pending_res[0].error_code, error_code);
					cmp("bad_block_total", pending_res[0].bad_total, bad_block_total);
					cmp("last", pending_res[0].last, last);
					void'(pending_res.pop_front());
				end
				n_checked++;
			end
			if (recv_stall != 0) begin
				recv_stall <= recv_stall - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				stall_pick = idle_len(n_checked);
				recv_stall <= stall_pick;
				out_ready <= (stall_pick == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input bit hold = 1'b0);
		tx_bytes.push_back(b);
		tx_hold.push_back(hold);
		n_gen++;
	endtask

	function automatic logic [11:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 12'h000;
		if (r == 1)
			return 12'hFFF;
		return 12'($urandom);
	endfunction

	// one block with a correct number and the latched length
	task automatic put_block(input logic [7:0] status, input bit bad_spare, input bit hold,
		input bit corner);
		logic [11:0] w0;
		logic [11:0] w1;
		logic [3:0]  spare;
		int          i;
		put_byte(status, hold);
		put_byte(g_blk[7:0]);
		put_byte(g_blk[15:8]);
		put_byte(g_len[7:0]);
		put_byte(g_len[15:8]);
		for (i = 0; i < g_len; i += 2) begin
			w0 = corner ? CORNER_WORDS[i % 8] : rand_word();
			g_sum = g_sum + w0;
			put_byte(w0[7:0]);
			if (i + 1 < g_len) begin
				w1 = corner ? CORNER_WORDS[(i + 1) % 8] : rand_word();
				g_sum = g_sum + w1;
				put_byte({w1[3:0], w0[11:8]});
				put_byte(w1[11:4]);
			end else begin
				spare = bad_spare ? 4'($urandom_range(1, 15)) : 4'h0;
				put_byte({spare, w0[11:8]});
			end
		end
		g_blk = g_blk + 16'd1;
		n_blocks++;
	endtask

	task automatic put_checksum(input bit good);
		logic [15:0] cs;
		cs[15:12] = 4'($urandom);
		cs[11:0] = 12'h000 - g_sum;
		if (!good)
			cs[11:0] = cs[11:0] + 12'($urandom_range(1, 4095));
		put_byte(STAT_SUM, 1'b1);
		put_byte(cs[7:0]);
		put_byte(cs[15:8]);
	endtask

	task automatic put_header(input logic [15:0] blk, input logic [15:0] len);
		put_byte(STAT_GOOD, 1'b1);
		put_byte(blk[7:0]);
		put_byte(blk[15:8]);
		put_byte(len[7:0]);
		put_byte(len[15:8]);
	endtask

	initial begin
		g_len = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 5)) : 16'($urandom_range(6, 40));
		if ($urandom_range(0, 15) == 0) begin
			// checksum straight after reset, no blocks at all
			put_checksum(1'b1);
			ending = "checksum before any block";
		end else begin
			put_block(STAT_GOOD, 1'b0, 1'b0, 1'b1);
			put_block(STAT_BAD, 1'b0, 1'b0, 1'b1);
			put_block(STAT_GOOD, 1'b0, 1'b1, 1'b0);
			while (n_gen < STREAM_BYTES)
				put_block(($urandom_range(0, 3) == 0) ? STAT_BAD : STAT_GOOD, 1'b0, 1'b0, 1'b0);
			case ($urandom_range(0, 7))
			0, 1: begin
				put_checksum(1'b1);
				ending = "good checksum";
			end
			2: begin
				put_byte(8'($urandom_range(0, 8'hFC)), 1'b1);
				ending = "unknown status byte";
			end
			3: begin
				put_header(g_blk ^ (16'h0001 << $urandom_range(0, 15)), g_len);
				ending = "wrong block number";
			end
			4: begin
				put_header(g_blk, g_len + 16'($urandom_range(1, 100)));
				ending = "length change";
			end
			5: begin
				if (g_len[0]) begin
					put_block(STAT_GOOD, 1'b1, 1'b1, 1'b0);
					ending = "nonzero spare nibble";
				end else begin
					put_checksum(1'b0);
					ending = "checksum mismatch";
				end
			end
			6: begin
				put_checksum(1'b0);
				ending = "checksum mismatch";
			end
			default: begin
				put_header(g_blk, 16'h0000);
				ending = "zero length";
			end
			endcase
		end
		// halted block must swallow these silently; the first waits for a full drain
		put_byte(8'($urandom), 1'b1);
		repeat (11)
			put_byte(8'($urandom));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_gen)
			@(posedge clk);
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Stream of %0d bytes, %0d blocks of %0d words, closed by %s.",
			n_gen, n_blocks, g_len, ending);
		$display("%0d results checked, %0d bad blocks seen.", n_checked, bad_cnt);
		if (pending_res.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_res.size());
			n_fail++;
		end
		if (n_fail == 0) begin
			$display("tape_block_stream_deframer verification clean");
		end else begin
			$display("tape_block_stream_deframer verification failed");
		end
		$finish;
	end

endmodule
